// ===== rtl/efd_pkg.sv =====
package efd_pkg;

    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 16;
    localparam int TDATA_W = 80;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;
    localparam logic [COUNT_W-1:0] HEADER_LEN = 16'd4;

    localparam logic [BYTE_W-1:0] DELIMITER_RESET = 8'h55;
    localparam logic [BYTE_W-1:0] ESCAPE_RESET    = 8'hDD;

    // Configuration register indexes.
    localparam logic REG_DELIMITER = 1'b0;
    localparam logic REG_ESCAPE    = 1'b1;

    // Result kinds carried on tuser.
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Header byte positions within a frame.
    localparam logic [COUNT_W-1:0] POS_FLAGS_LO = 16'd0;
    localparam logic [COUNT_W-1:0] POS_FLAGS_HI = 16'd1;
    localparam logic [COUNT_W-1:0] POS_ID       = 16'd2;
    localparam logic [COUNT_W-1:0] POS_CODE     = 16'd3;

    typedef struct packed {
        logic               in_frame;
        logic               escape_pending;
        logic [COUNT_W-1:0] byte_count;
        logic [15:0]        header_flags;
        logic [7:0]         header_id;
        logic [7:0]         header_code;
    } efd_state_t;

    typedef struct packed {
        logic               short_frame;
        logic [COUNT_W-1:0] frame_length;
        logic [7:0]         frame_code;
        logic [7:0]         frame_id;
        logic [15:0]        frame_flags;
        logic [COUNT_W-1:0] byte_index;
        logic [BYTE_W-1:0]  data_byte;
    } efd_result_t;

endpackage

// ===== rtl/escaped_frame_deframer_core.sv =====
// Channel   Direction  Beat contents
// s_axis    in         tdata[7:0] rx_byte
// m_axis    out        tuser result_kind; tdata packed result fields
// cfg       in         index 0 delimiter_byte, 1 escape_byte; data[7:0]
//
// One beat per cycle is sustained while m_axis is ready: a received byte is
// held in an input register, the frame logic runs once on it, and any result
// lands in the output register. The state update is one compare-and-count step.
// Reset clears the frame state and loads the default delimiter and escape.
// A stall on m_axis holds the output beat and backs up through both stages.
module escaped_frame_deframer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] data_byte, [23:8] byte_index, [39:24] frame_flags,
    // [47:40] frame_id, [55:48] frame_code, [71:56] frame_length,
    // [72] short_frame, [79:73] zero
    output logic [79:0] m_axis_tdata,
    output logic        m_axis_tuser,   // [0] result_kind
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);
    import efd_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg;
    efd_result_t out_result_reg;
    logic        out_kind_reg;
    efd_state_t  state_reg;
    efd_state_t  state_next;
    logic [7:0]  delimiter_reg;
    logic [7:0]  escape_reg;

    logic        step_fire;
    logic        result_valid;
    logic        result_kind;
    efd_result_t result;

    assign step_fire     = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || step_fire;
    assign cfg_ready     = 1'b1;

    efd_step u_step (
        .state          (state_reg),
        .rx_byte        (in_byte_reg),
        .delimiter_byte (delimiter_reg),
        .escape_byte    (escape_reg),
        .state_next     (state_next),
        .result_valid   (result_valid),
        .result_kind    (result_kind),
        .result         (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delimiter_reg <= DELIMITER_RESET;
            escape_reg    <= ESCAPE_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_DELIMITER: delimiter_reg <= cfg_data;
                REG_ESCAPE:    escape_reg    <= cfg_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (step_fire)
        begin
            state_reg     <= state_next;
            out_valid_reg <= result_valid;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_fire && result_valid)
        begin
            out_result_reg <= result;
            out_kind_reg   <= result_kind;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tdata  = {{(TDATA_W - $bits(efd_result_t)){1'b0}}, out_result_reg};

endmodule

// ===== rtl/efd_step.sv =====
module efd_step (
    input  efd_pkg::efd_state_t  state,
    input  logic [7:0]           rx_byte,
    input  logic [7:0]           delimiter_byte,
    input  logic [7:0]           escape_byte,
    output efd_pkg::efd_state_t  state_next,
    output logic                 result_valid,
    output logic                 result_kind,
    output efd_pkg::efd_result_t result
);
    import efd_pkg::*;

    logic is_delim;
    logic is_escape;

    assign is_delim  = (rx_byte == delimiter_byte) && !state.escape_pending;
    assign is_escape = (rx_byte == escape_byte) && state.in_frame && !state.escape_pending;

    always_comb
    begin
        state_next   = state;
        result_valid = 1'b0;
        result_kind  = KIND_BYTE;
        result       = '0;
        if (is_delim)
        begin
            if (!state.in_frame)
            begin
                state_next.in_frame     = 1'b1;
                state_next.byte_count   = '0;
                state_next.header_flags = '0;
                state_next.header_id    = '0;
                state_next.header_code  = '0;
            end
            else if (state.byte_count != '0)
            begin
                result_valid        = 1'b1;
                result_kind         = KIND_END;
                result.frame_flags  = state.header_flags;
                result.frame_id     = state.header_id;
                result.frame_code   = state.header_code;
                result.frame_length = state.byte_count;
                result.short_frame  = (state.byte_count < HEADER_LEN);
                state_next.in_frame   = 1'b0;
                state_next.byte_count = '0;
            end
        end
        else if (is_escape)
        begin
            state_next.escape_pending = 1'b1;
        end
        else
        begin
            state_next.escape_pending = 1'b0;
            if (state.in_frame)
            begin
                case (state.byte_count)
                    POS_FLAGS_LO: state_next.header_flags[7:0]  = rx_byte;
                    POS_FLAGS_HI: state_next.header_flags[15:8] = rx_byte;
                    POS_ID:       state_next.header_id          = rx_byte;
                    POS_CODE:     state_next.header_code        = rx_byte;
                    default:      ;
                endcase
                result_valid      = 1'b1;
                result_kind       = KIND_BYTE;
                result.data_byte  = rx_byte;
                result.byte_index = state.byte_count;
                // The count holds at its maximum once a frame grows that long.
                if (state.byte_count != COUNT_MAX)
                begin
                    state_next.byte_count = state.byte_count + 16'd1;
                end
            end
        end
    end

endmodule

// ===== verif/tb.sv =====
module tb;
    import efd_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] rx_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // [7:0] data_byte, [23:8] byte_index, [39:24] frame_flags,
    // [47:40] frame_id, [55:48] frame_code, [71:56] frame_length,
    // [72] short_frame, [79:73] zero
    logic [79:0] m_axis_tdata;
    logic        m_axis_tuser;   // [0] result_kind
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [7:0]  cfg_data;

    typedef struct {
        logic        kind;
        efd_result_t fields;
    } deframed_beat_t;

    // Tracks the deframer state and the beats it should produce, in order.
    class deframe_scoreboard;
        logic [7:0]     delim_reg;
        logic [7:0]     escape_reg;
        bit             in_frame;
        bit             escape_pending;
        logic [15:0]    byte_count;
        logic [15:0]    header_flags;
        logic [7:0]     header_id;
        logic [7:0]     header_code;
        deframed_beat_t pending_beats[$];
        int             errors;
        int             kept_bytes;
        int             frames_closed;
        int             short_frames;

        function new();
            delim_reg      = DELIMITER_RESET;
            escape_reg     = ESCAPE_RESET;
            in_frame       = 0;
            escape_pending = 0;
            byte_count     = '0;
            header_flags   = '0;
            header_id      = '0;
            header_code    = '0;
            errors         = 0;
            kept_bytes     = 0;
            frames_closed  = 0;
            short_frames   = 0;
        endfunction

        function void write_reg(logic idx, logic [7:0] value);
            if (idx == REG_DELIMITER)
                delim_reg = value;
            else
                escape_reg = value;
        endfunction

        function void take_byte(logic [7:0] b);
            deframed_beat_t beat;
            beat.kind   = KIND_BYTE;
            beat.fields = '0;
            // The delimiter test wins over the escape test when both match.
            if (b == delim_reg && !escape_pending) begin
                if (!in_frame) begin
                    in_frame     = 1;
                    byte_count   = '0;
                    header_flags = '0;
                    header_id    = '0;
                    header_code  = '0;
                end
                else if (byte_count != 0) begin
                    beat.kind                = KIND_END;
                    beat.fields.frame_flags  = header_flags;
                    beat.fields.frame_id     = header_id;
                    beat.fields.frame_code   = header_code;
                    beat.fields.frame_length = byte_count;
                    beat.fields.short_frame  = (byte_count < HEADER_LEN);
                    pending_beats.push_back(beat);
                    frames_closed++;
                    if (byte_count < HEADER_LEN)
                        short_frames++;
                    in_frame   = 0;
                    byte_count = '0;
                end
                return;
            end
            if (b == escape_reg && in_frame && !escape_pending) begin
                escape_pending = 1;
                return;
            end
            escape_pending = 0;
            if (!in_frame)
                return;
            case (byte_count)
                POS_FLAGS_LO: header_flags[7:0]  = b;
                POS_FLAGS_HI: header_flags[15:8] = b;
                POS_ID:       header_id          = b;
                POS_CODE:     header_code        = b;
                default:      ;
            endcase
            beat.fields.data_byte  = b;
            beat.fields.byte_index = byte_count;
            pending_beats.push_back(beat);
            kept_bytes++;
            if (byte_count != COUNT_MAX)
                byte_count = byte_count + 16'd1;
        endfunction

        function void check_beat(logic kind, logic [79:0] tdata);
            deframed_beat_t want;
            efd_result_t    got;
            bit             bad;
            got = tdata[72:0];
            if (pending_beats.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("Unexpected beat: kind %0d tdata %h", kind, tdata);
                return;
            end
            want = pending_beats.pop_front();
            bad = (kind !== want.kind)
                || (got.data_byte !== want.fields.data_byte)
                || (got.byte_index !== want.fields.byte_index)
                || (got.frame_flags !== want.fields.frame_flags)
                || (got.frame_id !== want.fields.frame_id)
                || (got.frame_code !== want.fields.frame_code)
                || (got.frame_length !== want.fields.frame_length)
                || (got.short_frame !== want.fields.short_frame)
                || (tdata[79:73] !== 7'd0);
            if (bad) begin
                errors++;
                if (errors <= 10) begin
                    $display(
                        "exp  kind=%0d byte=%h idx=%h flg=%h id=%h code=%h len=%h sh=%0d",
                        want.kind, want.fields.data_byte, want.fields.byte_index,
                        want.fields.frame_flags, want.fields.frame_id,
                        want.fields.frame_code, want.fields.frame_length,
                        want.fields.short_frame);
                    $display(
                        "got  kind=%0d byte=%h idx=%h flg=%h id=%h code=%h len=%h sh=%0d pad=%h",
                        kind, got.data_byte, got.byte_index, got.frame_flags,
                        got.frame_id, got.frame_code, got.frame_length,
                        got.short_frame, tdata[79:73]);
                end
            end
        endfunction
    endclass

    deframe_scoreboard sb = new();

    int bytes_in   = 0;
    int beats_out  = 0;
    int beats_seen = 0;
    int cfg_writes = 0;
    int stall_left = 0;
    bit steady     = 0;
    bit failed;

    escaped_frame_deframer_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // All three channels are observed here; output beats are checked before
    // the byte accepted on the same edge is fed to the predictor.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_beat(m_axis_tuser, m_axis_tdata);
                beats_out++;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                sb.take_byte(s_axis_tdata);
                bytes_in++;
            end
            if (cfg_valid && cfg_ready) begin
                sb.write_reg(cfg_index, cfg_data);
                cfg_writes++;
            end
        end
    end

    // Receiver: after every beat it draws a fresh stall length.
    always @(negedge clk)
    begin
        if (beats_out != beats_seen) begin
            beats_seen = beats_out;
            stall_left = steady ? 0 : $urandom_range(0, 16);
        end
        if (stall_left > 0) begin
            m_axis_tready = 1'b0;
            stall_left--;
        end
        else begin
            m_axis_tready = 1'b1;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        int start;
        gap = steady ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata  = b;
        s_axis_tvalid = 1'b1;
        start = bytes_in;
        while (bytes_in == start) @(negedge clk);
    endtask

    // Escapes a payload byte that would otherwise be taken as a marker.
    task automatic send_payload(input logic [7:0] b);
        if (b == sb.delim_reg || b == sb.escape_reg)
            send_byte(sb.escape_reg);
        send_byte(b);
    endtask

    task automatic send_frame(input int len);
        send_byte(sb.delim_reg);
        repeat (len) send_payload(8'($urandom_range(0, 255)));
        send_byte(sb.delim_reg);
    endtask

    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (sb.pending_beats.size() != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_marker(input logic idx, input logic [7:0] value);
        int start;
        cfg_index = idx;
        cfg_data  = value;
        cfg_valid = 1'b1;
        start = cfg_writes;
        while (cfg_writes == start) @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_markers(input logic [7:0] delim, input logic [7:0] esc);
        drain();
        write_marker(REG_DELIMITER, delim);
        write_marker(REG_ESCAPE, esc);
    endtask

    // Mostly well-formed frames with random payload, plus line noise and
    // frames broken by stray escapes, and it switches gap-free timing on and off.
    task automatic run_random(input int count);
        int done;
        int pick;
        int len;
        done = 0;
        while (done < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 40)
                                                  : $urandom_range(0, 8);
                send_frame(len);
                done += len + 2;
            end
            else if (pick < 85) begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
            end
            else if (pick < 95) begin
                send_byte(sb.delim_reg);
                repeat ($urandom_range(0, 3)) send_payload(8'($urandom_range(0, 255)));
                send_byte(sb.escape_reg);
                if ($urandom_range(0, 1))
                    send_byte(sb.delim_reg);
                else
                    send_byte(8'($urandom_range(0, 255)));
                done += 3;
            end
            else begin
                steady = ~steady;
            end
        end
        steady = 0;
    endtask

    initial
    begin
        logic [7:0] directed [] = '{8'hDD, 8'h12, 8'h55, 8'h55, 8'h00, 8'hFF, 8'hDD,
                                    8'h55, 8'hDD, 8'hDD, 8'h80, 8'h01, 8'h55, 8'h55,
                                    8'hA5, 8'h55, 8'h55, 8'h5A, 8'h3C, 8'h55, 8'h55,
                                    8'h11};
        logic [7:0] equal_run [] = '{8'hAA, 8'h01, 8'hAA, 8'hAA, 8'h02, 8'hAA};
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        cfg_valid     = 1'b0;
        cfg_index     = REG_DELIMITER;
        cfg_data      = 8'h00;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (3) @(negedge clk);

        // Reset markers: stray escape outside a frame, delimiter in an empty
        // frame, escaped markers as data, short frames, and a frame left open
        // across the next marker change.
        foreach (directed[i]) send_byte(directed[i]);

        set_markers(8'h00, 8'hFF);
        run_random(100);
        set_markers(8'hFF, 8'h00);
        run_random(100);
        set_markers(8'h7E, 8'h7D);
        run_random(50);
        drain();
        run_random(50);

        // Delimiter and escape share one value.
        set_markers(8'hAA, 8'hAA);
        foreach (equal_run[i]) send_byte(equal_run[i]);
        run_random(60);

        set_markers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        run_random(100);

        set_markers(DELIMITER_RESET, ESCAPE_RESET);
        run_random(80);

        drain();
        $display("Checked %0d kept bytes and %0d closed frames (%0d short).",
                 sb.kept_bytes, sb.frames_closed, sb.short_frames);
        $display("Six marker settings were used, including extremes and equal markers.");
        failed = (sb.errors != 0) || (sb.pending_beats.size() != 0);
        if (sb.errors != 0)
            $display("%0d beat errors", sb.errors);
        if (!failed)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Timeout with %0d beats outstanding", sb.pending_beats.size());
        $display("== FAIL ==");
        $finish;
    end
endmodule
